FILE: hw/rtl/tvpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvpf_pkg
// Shared types and constants of the typed value packet framer.
// ----------------------------------------------------------------------------
package tvpf_pkg;

	localparam int MODE_W    = 3;
	localparam int VALUE_W   = 32;
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 16;
	localparam int MAX_BYTES = 5;   // flush plus four int bytes
	localparam int CNT_W     = 3;
	localparam int CFG_IDX_W = 4;

	localparam logic [MODE_W-1:0] MODE_START = 3'd0;
	localparam logic [MODE_W-1:0] MODE_BOOL  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BYTE  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SHORT = 3'd3;
	localparam logic [MODE_W-1:0] MODE_INT   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_FLOAT = 3'd5;
	localparam logic [MODE_W-1:0] MODE_END   = 3'd6;

	localparam logic [CFG_IDX_W-1:0] REG_HEAD = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL = 4'd1;

	localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hA5;
	localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h5A;

	// One queue entry: the bytes one item causes, first byte in octets[0].
	typedef struct packed {
		logic [MAX_BYTES-1:0][BYTE_W-1:0] octets;
		logic [CNT_W-1:0]                 cnt;
		logic                             last;  // final byte is the tail
		logic [LEN_W-1:0]                 len;
	} entry_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tvpf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvpf_if
// Valid/ready channels of the framer: input items, packet bytes, register writes.
// ----------------------------------------------------------------------------
interface tvpf_item_if;
	import tvpf_pkg::*;
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [VALUE_W-1:0] value;
	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

interface tvpf_byte_if;
	import tvpf_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last;
	logic [LEN_W-1:0]  packet_length;
	modport source (output valid, output out_byte, output last, output packet_length,
		input ready);
	modport sink (input valid, input out_byte, input last, input packet_length,
		output ready);
endinterface

interface tvpf_cfg_if;
	import tvpf_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/typed_value_packet_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// typed_value_packet_framer
// Frames typed values into head / payload / checksum / tail byte packets.
// ----------------------------------------------------------------------------
// Usage:
//  - item: one typed value per item (mode, value). Start opens a packet with
//    the head byte; bool, byte, short, int and float add payload; end closes
//    it with the 8-bit checksum and the tail byte.
//  - pkt: packet bytes in order, one per item on this channel. last marks the
//    tail byte and packet_length (head to tail, mod 65536) is given with it.
//  - cfg: index 0 writes the head byte, index 1 the tail byte; other indexes
//    are dropped. Always ready; write only while the framer is idle.
// Timing: an item is taken every cycle while the entry queue has room. Its
//  first byte is offered once its entry has passed the queue into the
//  serialiser, which sends one byte per cycle while pkt is ready. An item
//  causes 0 to 5 bytes, five for an int or float behind a partial bool byte.
// Reset: head/tail return to 0xA5/0x5A, any open packet is dropped and the
//  queue is emptied. A stalled pkt receiver holds the current byte; the queue
//  then fills and item.ready falls.
// ----------------------------------------------------------------------------
module typed_value_packet_framer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tvpf_item_if.sink   item,
	tvpf_byte_if.source pkt,
	tvpf_cfg_if.sink    cfg
);
	import tvpf_pkg::*;

	logic [BYTE_W-1:0] head_q;
	logic [BYTE_W-1:0] tail_q;

	// front -> queue
	logic   push_valid, push_ready;
	entry_t push_data;
	// queue -> back
	logic   pop_valid, pop_ready;
	entry_t pop_data;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= HEAD_RESET;
			tail_q <= TAIL_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_HEAD: head_q <= cfg.data;
				REG_TAIL: tail_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// classify items and keep packet state
	tvpf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.head_byte  (head_q),
		.tail_byte  (tail_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decouples item intake from byte output
	tvpf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// byte serialiser
	tvpf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.pkt       (pkt)
	);

endmodule
`default_nettype wire

FILE: hw/rtl/tvpf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvpf_front
// Takes items, tracks packet state and turns each item that yields bytes into one queue entry.
// ----------------------------------------------------------------------------
module tvpf_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	tvpf_item_if.sink                   item,
	input  wire logic [tvpf_pkg::BYTE_W-1:0] head_byte,
	input  wire logic [tvpf_pkg::BYTE_W-1:0] tail_byte,
	output      logic                   push_valid,
	input  wire logic                   push_ready,
	output      tvpf_pkg::entry_t       push_data
);
	import tvpf_pkg::*;

	logic                  open_q, open_n;
	logic [MODE_W-1:0]     rank_q, rank_n;
	logic [2:0]            bit_cnt_q, bit_cnt_n;
	logic [BYTE_W-1:0]     acc_q, acc_n;
	logic [BYTE_W-1:0]     sum_q, sum_n;
	logic [LEN_W-1:0]      count_q, count_n;
	logic                  emit;
	logic                  flush;
	logic [BYTE_W-1:0]     v0, v1, v2, v3;
	logic [BYTE_W-1:0]     bool_acc;
	logic [BYTE_W-1:0]     vsum;
	logic [BYTE_W-1:0]     sum_f;
	logic [CNT_W-1:0]      nbytes;
	logic                  take;

	assign take       = item.valid & item.ready;
	assign item.ready = push_ready;
	assign push_valid = item.valid & emit;

	assign flush = (bit_cnt_q != 3'd0);
	assign v0 = item.value[7:0];
	assign v1 = item.value[15:8];
	assign v2 = item.value[23:16];
	assign v3 = item.value[31:24];
	assign bool_acc = acc_q | (BYTE_W'(item.value[0]) << bit_cnt_q);
	assign sum_f = sum_q + (flush ? acc_q : 8'h00);

	always_comb begin
		nbytes = 3'd4;
		vsum   = v0 + v1 + v2 + v3;
		unique case (item.mode) inside
			MODE_BYTE: begin
				nbytes = 3'd1;
				vsum   = v0;
			end
			MODE_SHORT: begin
				nbytes = 3'd2;
				vsum   = v0 + v1;
			end
			default: begin
				nbytes = 3'd4;
				vsum   = v0 + v1 + v2 + v3;
			end
		endcase
	end

	always_comb begin
		emit      = 1'b0;
		push_data = '0;
		open_n    = open_q;
		rank_n    = rank_q;
		bit_cnt_n = bit_cnt_q;
		acc_n     = acc_q;
		sum_n     = sum_q;
		count_n   = count_q;
		unique case (item.mode) inside
			MODE_START: begin
				emit                = 1'b1;
				push_data.octets[0] = head_byte;
				push_data.cnt       = 3'd1;
				open_n    = 1'b1;
				rank_n    = '0;
				bit_cnt_n = '0;
				acc_n     = '0;
				sum_n     = '0;
				count_n   = 16'd1;
			end
			MODE_END: begin
				if (open_q) begin
					emit           = 1'b1;
					push_data.last = 1'b1;
					if (flush) begin
						push_data.octets = {16'h0000, tail_byte, sum_f, acc_q};
						push_data.cnt    = 3'd3;
						push_data.len    = count_q + 16'd3;
					end else begin
						push_data.octets = {24'h000000, tail_byte, sum_f};
						push_data.cnt    = 3'd2;
						push_data.len    = count_q + 16'd2;
					end
					open_n    = 1'b0;
					rank_n    = '0;
					bit_cnt_n = '0;
					acc_n     = '0;
					sum_n     = '0;
					count_n   = '0;
				end
			end
			MODE_BOOL: begin
				if (open_q && item.mode >= rank_q) begin
					rank_n = item.mode;
					if (bit_cnt_q == 3'd7) begin
						emit                = 1'b1;
						push_data.octets[0] = bool_acc;
						push_data.cnt       = 3'd1;
						sum_n     = sum_q + bool_acc;
						count_n   = count_q + 16'd1;
						bit_cnt_n = '0;
						acc_n     = '0;
					end else begin
						bit_cnt_n = bit_cnt_q + 3'd1;
						acc_n     = bool_acc;
					end
				end
			end
			MODE_BYTE, MODE_SHORT, MODE_INT, MODE_FLOAT: begin
				if (open_q && item.mode >= rank_q) begin
					emit   = 1'b1;
					rank_n = item.mode;
					if (flush) begin
						push_data.octets = {v3, v2, v1, v0, acc_q};
						push_data.cnt    = nbytes + 3'd1;
					end else begin
						push_data.octets = {8'h00, v3, v2, v1, v0};
						push_data.cnt    = nbytes;
					end
					sum_n     = sum_f + vsum;
					count_n   = count_q + LEN_W'(push_data.cnt);
					bit_cnt_n = '0;
					acc_n     = '0;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			rank_q    <= '0;
			bit_cnt_q <= '0;
			acc_q     <= '0;
			sum_q     <= '0;
			count_q   <= '0;
		end else if (take) begin
			open_q    <= open_n;
			rank_q    <= rank_n;
			bit_cnt_q <= bit_cnt_n;
			acc_q     <= acc_n;
			sum_q     <= sum_n;
			count_q   <= count_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_closed_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> (bit_cnt_q == 3'd0 && rank_q == '0 && count_q == '0))
		else $error("closed packet holds leftover state");
	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (push_data.cnt != '0 && push_data.cnt <= CNT_W'(MAX_BYTES)))
		else $error("entry byte count out of range");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/tvpf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvpf_queue
// Short entry queue between the front and the byte serialiser.
// ----------------------------------------------------------------------------
module tvpf_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output      logic             push_ready,
	input  wire tvpf_pkg::entry_t push_data,
	output      logic             pop_valid,
	input  wire logic             pop_ready,
	output      tvpf_pkg::entry_t pop_data
);
	import tvpf_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push, pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push = push_valid & push_ready;
	assign pop  = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill beyond depth");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/tvpf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvpf_back
// Serialises queue entries into packet bytes, one byte per cycle while pkt is ready.
// ----------------------------------------------------------------------------
module tvpf_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pop_valid,
	output      logic             pop_ready,
	input  wire tvpf_pkg::entry_t pop_data,
	tvpf_byte_if.source           pkt
);
	import tvpf_pkg::*;

	logic [MAX_BYTES-1:0][BYTE_W-1:0] octets_q;
	logic [CNT_W-1:0]                 rem_q;
	logic                             last_q;
	logic [LEN_W-1:0]                 len_q;
	logic                             take, final_b, load;

	assign pkt.valid = (rem_q != '0);
	assign take      = pkt.valid & pkt.ready;
	assign final_b   = (rem_q == CNT_W'(1));
	// next entry loads on the same edge that the final byte leaves
	assign load      = !pkt.valid || (take && final_b);
	assign pop_ready = load;

	assign pkt.out_byte      = octets_q[0];
	assign pkt.last          = last_q & final_b;
	assign pkt.packet_length = pkt.last ? len_q : '0;

	always_ff @(posedge clk) begin
		if (load && pop_valid) begin
			octets_q <= pop_data.octets;
			last_q   <= pop_data.last;
			len_q    <= pop_data.len;
		end else if (take) begin
			octets_q <= {{BYTE_W{1'b0}}, octets_q[MAX_BYTES-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load && pop_valid) begin
			rem_q <= pop_data.cnt;
		end else if (take) begin
			rem_q <= rem_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= CNT_W'(MAX_BYTES))
		else $error("remaining byte count out of range");
	a_no_early_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt.valid && !pkt.ready) |-> !pop_ready)
		else $error("entry popped while a byte is stalled");
`endif

endmodule
`default_nettype wire
